/* hw/rtl/dca_pkg.sv */
// ----------------------------------------------------------------------------
// dca_pkg
// Shared types and constants for the descriptor chain allocator.
// ----------------------------------------------------------------------------
package dca_pkg;

   localparam int HEAD_W  = 4;
   localparam int IDX_W   = 3;
   localparam int COUNT_W = 4;
   localparam int FLAG_W  = 2;
   localparam int POST_W  = 16;
   localparam int SEL_W   = 2;

   // link flag bits
   localparam logic [FLAG_W-1:0] FLAG_NONE  = 2'b00;
   localparam logic [FLAG_W-1:0] FLAG_NEXT  = 2'b01;
   localparam logic [FLAG_W-1:0] FLAG_DEVWR = 2'b10;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // chain position inside an allocation
   localparam logic [SEL_W-1:0] SEL_HEAD   = 2'd0;
   localparam logic [SEL_W-1:0] SEL_DATA   = 2'd1;
   localparam logic [SEL_W-1:0] SEL_STATUS = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOSPACE = 2'd1,
      STATUS_RANGE   = 2'd2,
      STATUS_FREE    = 2'd3
   } status_type;

   typedef struct packed {
      logic              mode;
      logic              is_write;
      logic [HEAD_W-1:0] head_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [IDX_W-1:0]   first_index;
      logic [IDX_W-1:0]   second_index;
      logic [IDX_W-1:0]   third_index;
      logic [IDX_W-1:0]   avail_slot;
      logic [COUNT_W-1:0] freed_count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic             load;
      logic             scan;
      logic             write;
      logic [SEL_W-1:0] sel;
      logic             check;
      logic             follow;
      logic             set_code;
      status_type       code;
      logic             publish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic found;
      logic in_range;
      logic cur_free;
      logic link_next;
   } stat_type;

endpackage

/* hw/rtl/dca_stream_if.sv */
// ----------------------------------------------------------------------------
// dca_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface dca_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/dca_datapath.sv */
// ----------------------------------------------------------------------------
// dca_datapath
// Free map, link memory, lowest-free search, chain walk and result register.
// ----------------------------------------------------------------------------
module dca_datapath #(
   parameter int TABLE_SIZE = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  dca_pkg::cmd_type  cmd,
   input  dca_pkg::req_type  req,
   output dca_pkg::stat_type stat,
   output dca_pkg::rsp_type  rsp
);

   localparam int IW = $clog2(TABLE_SIZE);
   localparam int CW = (IW > dca_pkg::HEAD_W) ? IW : dca_pkg::HEAD_W;
   localparam int OW = (IW > dca_pkg::IDX_W) ? IW : dca_pkg::IDX_W;
   localparam int LW = dca_pkg::FLAG_W + IW;

   logic [TABLE_SIZE-1:0]         free_ff, free_in;
   logic [TABLE_SIZE-1:0]         scan_ff, scan_in;
   logic [dca_pkg::POST_W-1:0]    posted_ff, posted_in;
   logic [IW-1:0]                 slot_ff, slot_in;
   logic                          mode_ff, mode_in;
   logic                          is_write_ff, is_write_in;
   logic [CW-1:0]                 cur_ff, cur_in;
   logic [IW-1:0]                 idx_ff [3];
   logic [IW-1:0]                 idx_in [3];
   dca_pkg::status_type           code_ff, code_in;
   logic [dca_pkg::COUNT_W-1:0]   freed_ff, freed_in;
   dca_pkg::rsp_type              rsp_ff, rsp_in;
   logic [LW-1:0]                 rd_ff;

   logic [LW-1:0] link_mem [TABLE_SIZE];

   logic                 found;
   logic [IW-1:0]        pos;
   logic                 in_range;
   logic [IW-1:0]        cur_idx;
   logic                 cur_free;
   logic                 release_cur;
   logic [IW-1:0]        wr_idx;
   logic [LW-1:0]        wr_data;
   logic [IW-1:0]        rd_next;
   logic                 ok_alloc;
   logic [OW-1:0]        idx0_w, idx1_w, idx2_w, slot_w;

   // lowest free descriptor among those not yet picked
   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
         if (scan_ff[i]) begin
            found = 1'b1;
            pos   = IW'(i);
         end
      end
   end

   assign in_range    = ({1'b0, cur_ff} < (CW + 1)'(TABLE_SIZE));
   assign cur_idx     = cur_ff[IW-1:0];
   assign cur_free    = in_range ? free_ff[cur_idx] : 1'b1;
   assign release_cur = cmd.check && !cur_free;
   assign rd_next     = rd_ff[IW-1:0];

   always_comb begin
      unique case (cmd.sel)
         dca_pkg::SEL_HEAD: begin
            wr_idx  = idx_ff[0];
            wr_data = {dca_pkg::FLAG_NEXT, idx_ff[1]};
         end
         dca_pkg::SEL_DATA: begin
            wr_idx  = idx_ff[1];
            wr_data = {dca_pkg::FLAG_NEXT | (is_write_ff ? dca_pkg::FLAG_NONE
                                                         : dca_pkg::FLAG_DEVWR),
                       idx_ff[2]};
         end
         default: begin
            wr_idx  = idx_ff[2];
            wr_data = {dca_pkg::FLAG_DEVWR, IW'(0)};
         end
      endcase
   end

   assign stat.found     = found;
   assign stat.in_range  = in_range;
   assign stat.cur_free  = cur_free;
   assign stat.link_next = rd_ff[IW];

   assign ok_alloc = (mode_ff == dca_pkg::MODE_ALLOC) && (code_ff == dca_pkg::STATUS_OK);
   assign idx0_w   = OW'(idx_ff[0]);
   assign idx1_w   = OW'(idx_ff[1]);
   assign idx2_w   = OW'(idx_ff[2]);
   assign slot_w   = OW'(slot_ff);

   always_comb begin
      free_in     = free_ff;
      scan_in     = scan_ff;
      posted_in   = posted_ff;
      slot_in     = slot_ff;
      mode_in     = mode_ff;
      is_write_in = is_write_ff;
      cur_in      = cur_ff;
      idx_in      = idx_ff;
      code_in     = code_ff;
      freed_in    = freed_ff;
      rsp_in      = rsp_ff;

      if (cmd.load) begin
         mode_in     = req.mode;
         is_write_in = req.is_write;
         cur_in      = CW'(req.head_index);
         scan_in     = free_ff;
         code_in     = dca_pkg::STATUS_OK;
         freed_in    = '0;
         idx_in[0]   = '0;
         idx_in[1]   = '0;
         idx_in[2]   = '0;
      end
      if (cmd.scan && found) begin
         unique case (cmd.sel)
            dca_pkg::SEL_HEAD: idx_in[0] = pos;
            dca_pkg::SEL_DATA: idx_in[1] = pos;
            default:           idx_in[2] = pos;
         endcase
         scan_in[pos] = 1'b0;
      end
      if (cmd.write) begin
         free_in[wr_idx] = 1'b0;
      end
      if (release_cur) begin
         free_in[cur_idx] = 1'b1;
         freed_in         = freed_ff + 1'b1;
      end
      if (cmd.follow) begin
         cur_in = CW'(rd_next);
      end
      if (cmd.set_code) begin
         code_in = cmd.code;
      end
      if (cmd.publish) begin
         rsp_in.status       = code_ff;
         rsp_in.first_index  = ok_alloc ? idx0_w[dca_pkg::IDX_W-1:0] : '0;
         rsp_in.second_index = ok_alloc ? idx1_w[dca_pkg::IDX_W-1:0] : '0;
         rsp_in.third_index  = ok_alloc ? idx2_w[dca_pkg::IDX_W-1:0] : '0;
         rsp_in.avail_slot   = ok_alloc ? slot_w[dca_pkg::IDX_W-1:0] : '0;
         rsp_in.freed_count  = (mode_ff == dca_pkg::MODE_ALLOC) ? '0 : freed_ff;
         if (ok_alloc) begin
            posted_in = posted_ff + 1'b1;
            // slot tracks posted count mod table size, including the 16-bit wrap
            if (posted_ff == '1 || slot_ff == IW'(TABLE_SIZE - 1)) begin
               slot_in = '0;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff   <= '1;
         posted_ff <= '0;
         slot_ff   <= '0;
      end else begin
         free_ff   <= free_in;
         posted_ff <= posted_in;
         slot_ff   <= slot_in;
      end
      scan_ff     <= scan_in;
      mode_ff     <= mode_in;
      is_write_ff <= is_write_in;
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      code_ff     <= code_in;
      freed_ff    <= freed_in;
      rsp_ff      <= rsp_in;
   end

   // link memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         link_mem[wr_idx] <= wr_data;
      end
      if (release_cur) begin
         rd_ff <= link_mem[cur_idx];
      end
   end

   assign rsp = rsp_ff;

endmodule

/* hw/rtl/dca_ctrl.sv */
// ----------------------------------------------------------------------------
// dca_ctrl
// Sequencer for allocate and free transactions and the response handshake.
// ----------------------------------------------------------------------------
module dca_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_mode,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  dca_pkg::stat_type stat,
   output dca_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_CHECK,
      ST_FETCH,
      ST_DONE
   } state_type;

   state_type                 state_ff;
   logic [dca_pkg::SEL_W-1:0] sel_ff;
   logic                      rsp_valid_ff;

   // no transaction is taken while reset is held
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.sel      = sel_ff;
      cmd.code     = dca_pkg::STATUS_OK;
      unique case (state_ff)
         ST_IDLE:  cmd.load = req_valid;
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (!stat.found) begin
               cmd.set_code = 1'b1;
               cmd.code     = dca_pkg::STATUS_NOSPACE;
            end
         end
         ST_WRITE: cmd.write = 1'b1;
         ST_CHECK: begin
            cmd.check = 1'b1;
            priority if (!stat.in_range) begin
               cmd.set_code = 1'b1;
               cmd.code     = dca_pkg::STATUS_RANGE;
            end else if (stat.cur_free) begin
               cmd.set_code = 1'b1;
               cmd.code     = dca_pkg::STATUS_FREE;
            end
         end
         ST_FETCH: cmd.follow  = stat.link_next;
         ST_DONE:  cmd.publish = !rsp_valid_ff || rsp_ready;
         default:  cmd.load    = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= dca_pkg::SEL_HEAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               sel_ff <= dca_pkg::SEL_HEAD;
               if (req_valid) begin
                  state_ff <= (req_mode == dca_pkg::MODE_ALLOC) ? ST_SCAN : ST_CHECK;
               end
            end
            ST_SCAN: begin
               if (!stat.found) begin
                  state_ff <= ST_DONE;
               end else if (sel_ff == dca_pkg::SEL_STATUS) begin
                  state_ff <= ST_WRITE;
                  sel_ff   <= dca_pkg::SEL_HEAD;
               end else begin
                  sel_ff <= sel_ff + 1'b1;
               end
            end
            ST_WRITE: begin
               if (sel_ff == dca_pkg::SEL_STATUS) begin
                  state_ff <= ST_DONE;
               end else begin
                  sel_ff <= sel_ff + 1'b1;
               end
            end
            ST_CHECK: begin
               state_ff <= (!stat.in_range || stat.cur_free) ? ST_DONE : ST_FETCH;
            end
            ST_FETCH: begin
               state_ff <= stat.link_next ? ST_CHECK : ST_DONE;
            end
            ST_DONE: begin
               if (cmd.publish) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* hw/rtl/descriptor_chain_allocator.sv */
// ----------------------------------------------------------------------------
// descriptor_chain_allocator
// Split-queue descriptor allocator: three-descriptor chains, chain release.
// ----------------------------------------------------------------------------
// Handles one transaction at a time. An allocate passes through acceptance,
// three lowest-free searches and three writes of the head, data and status
// links through the single write port of the link memory, then the response.
// A free walks the chain with a check and a fetch per released descriptor,
// the fetch using the registered read of the link memory; a walk that ends
// on an error ends with one more check. The response register holds a
// finished result until it is taken; the next request is accepted once that
// result has been loaded.
// ----------------------------------------------------------------------------
module descriptor_chain_allocator #(
   parameter int TABLE_SIZE = 8
) (
   input logic         clock,
   input logic         reset,
   dca_stream_if.sink   req_if,
   dca_stream_if.source rsp_if
);

   dca_pkg::cmd_type  cmd;
   dca_pkg::stat_type stat;
   dca_pkg::req_type  req;
   dca_pkg::rsp_type  rsp;

   assign req = req_if.payload;

   dca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_mode  (req.mode),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dca_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req),
      .stat  (stat),
      .rsp   (rsp)
   );

   assign rsp_if.payload = rsp;

endmodule

/* sim/descriptor_chain_allocator_test.sv */
// ----------------------------------------------------------------------------
// descriptor_chain_allocator_test
// Drives allocate and free transactions into the descriptor chain allocator
// and checks every response against a cycle-free model of the descriptor
// table, with random idling on both channels.
// ----------------------------------------------------------------------------
module descriptor_chain_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SIZE = 8;
   localparam int RANDOM_ITEMS = 750;
   localparam int DRAIN_CYCLES = 40;

   // Model of the descriptor table plus the queue of responses still owed.
   class descriptor_table_model;
      bit                                free_map[TABLE_SIZE];
      logic [dca_pkg::FLAG_W-1:0]        link_flags[TABLE_SIZE];
      logic [dca_pkg::IDX_W-1:0]         link_next[TABLE_SIZE];
      logic [dca_pkg::POST_W-1:0]        posted_count;
      dca_pkg::rsp_type                  awaited_rsp[$];
      int                                mismatches;

      function new();
         for (int i = 0; i < TABLE_SIZE; i++) begin
            free_map[i]   = 1'b1;
            link_flags[i] = dca_pkg::FLAG_NONE;
            link_next[i]  = '0;
         end
         posted_count = '0;
         mismatches   = 0;
      endfunction

      task report(input string msg);
         $display("%0t ns: %s", $time, msg);
         mismatches++;
      endtask

      // Applies one accepted request to the table and queues its response.
      function dca_pkg::rsp_type note_request(input dca_pkg::req_type r);
         dca_pkg::rsp_type           want;
         int                         picks[3];
         int                         found;
         int                         cur;
         logic [dca_pkg::FLAG_W-1:0] fl;
         logic [dca_pkg::IDX_W-1:0]  nx;
         want  = '0;
         found = 0;
         if (r.mode == dca_pkg::MODE_ALLOC) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
               if (free_map[i] && found < 3) begin
                  picks[found] = i;
                  found++;
               end
            end
            if (found < 3) begin
               want.status = dca_pkg::STATUS_NOSPACE;
            end else begin
               for (int k = 0; k < 3; k++) free_map[picks[k]] = 1'b0;
               link_flags[picks[0]] = dca_pkg::FLAG_NEXT;
               link_next[picks[0]]  = dca_pkg::IDX_W'(picks[1]);
               // a disk read means the device fills the data buffer
               link_flags[picks[1]] = r.is_write ? dca_pkg::FLAG_NEXT
                                                 : (dca_pkg::FLAG_NEXT | dca_pkg::FLAG_DEVWR);
               link_next[picks[1]]  = dca_pkg::IDX_W'(picks[2]);
               link_flags[picks[2]] = dca_pkg::FLAG_DEVWR;
               link_next[picks[2]]  = '0;
               want.status       = dca_pkg::STATUS_OK;
               want.first_index  = dca_pkg::IDX_W'(picks[0]);
               want.second_index = dca_pkg::IDX_W'(picks[1]);
               want.third_index  = dca_pkg::IDX_W'(picks[2]);
               want.avail_slot   = dca_pkg::IDX_W'(int'(posted_count) % TABLE_SIZE);
               posted_count++;
            end
         end else begin
            want.status = dca_pkg::STATUS_OK;
            cur = r.head_index;
            for (int steps = 0; steps <= TABLE_SIZE; steps++) begin
               if (cur >= TABLE_SIZE) begin
                  want.status = dca_pkg::STATUS_RANGE;
                  break;
               end
               if (free_map[cur]) begin
                  want.status = dca_pkg::STATUS_FREE;
                  break;
               end
               fl = link_flags[cur];
               nx = link_next[cur];
               link_flags[cur] = dca_pkg::FLAG_NONE;
               link_next[cur]  = '0;
               free_map[cur]   = 1'b1;
               want.freed_count++;
               if ((fl & dca_pkg::FLAG_NEXT) != dca_pkg::FLAG_NONE) cur = nx;
               else break;
            end
         end
         awaited_rsp.push_back(want);
         return want;
      endfunction

      task check_response(input dca_pkg::rsp_type got);
         dca_pkg::rsp_type want;
         if (awaited_rsp.size() == 0) begin
            report($sformatf("response with none outstanding: %p", got));
         end else begin
            want = awaited_rsp.pop_front();
            if (got.status !== want.status)
               report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.first_index !== want.first_index)
               report($sformatf("first_index got %0d want %0d",
                                got.first_index, want.first_index));
            if (got.second_index !== want.second_index)
               report($sformatf("second_index got %0d want %0d",
                                got.second_index, want.second_index));
            if (got.third_index !== want.third_index)
               report($sformatf("third_index got %0d want %0d",
                                got.third_index, want.third_index));
            if (got.avail_slot !== want.avail_slot)
               report($sformatf("avail_slot got %0d want %0d",
                                got.avail_slot, want.avail_slot));
            if (got.freed_count !== want.freed_count)
               report($sformatf("freed_count got %0d want %0d",
                                got.freed_count, want.freed_count));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm  = 1'b0;

   dca_stream_if #(.payload_type(dca_pkg::req_type)) req_if ();
   dca_stream_if #(.payload_type(dca_pkg::rsp_type)) rsp_if ();

   descriptor_chain_allocator #(.TABLE_SIZE(TABLE_SIZE)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   descriptor_table_model         table_model = new();
   logic [dca_pkg::HEAD_W-1:0]    live_heads[$];

   // walks through every response code, broken chains and a chain that runs
   // into a later allocation
   dca_pkg::req_type directed [20] = '{
      '{dca_pkg::MODE_ALLOC, 1'b0, 4'd0},  '{dca_pkg::MODE_ALLOC, 1'b1, 4'd9},
      '{dca_pkg::MODE_ALLOC, 1'b1, 4'd6},  '{dca_pkg::MODE_FREE,  1'b0, 4'd15},
      '{dca_pkg::MODE_FREE,  1'b1, 4'd8},  '{dca_pkg::MODE_FREE,  1'b0, 4'd6},
      '{dca_pkg::MODE_FREE,  1'b1, 4'd4},  '{dca_pkg::MODE_FREE,  1'b0, 4'd3},
      '{dca_pkg::MODE_FREE,  1'b1, 4'd0},  '{dca_pkg::MODE_FREE,  1'b0, 4'd0},
      '{dca_pkg::MODE_ALLOC, 1'b1, 4'd0},  '{dca_pkg::MODE_ALLOC, 1'b0, 4'd5},
      '{dca_pkg::MODE_FREE,  1'b1, 4'd1},  '{dca_pkg::MODE_FREE,  1'b0, 4'd2},
      '{dca_pkg::MODE_ALLOC, 1'b0, 4'd10}, '{dca_pkg::MODE_FREE,  1'b0, 4'd0},
      '{dca_pkg::MODE_FREE,  1'b1, 4'd4},  '{dca_pkg::MODE_FREE,  1'b0, 4'd7},
      '{dca_pkg::MODE_FREE,  1'b1, 4'd12}, '{dca_pkg::MODE_ALLOC, 1'b1, 4'd0}
   };

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // response side: random back-pressure, checks each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) table_model.check_response(rsp_if.payload);
         rsp_if.ready <= calm || ($urandom_range(99) >= 17);
      end
   end

   task automatic send_request(input dca_pkg::req_type r);
      dca_pkg::rsp_type want;
      if (!calm) begin
         while ($urandom_range(99) < 17) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      want = table_model.note_request(r);
      if (r.mode == dca_pkg::MODE_ALLOC && want.status == dca_pkg::STATUS_OK)
         live_heads.push_back(dca_pkg::HEAD_W'(want.first_index));
   endtask

   // allocations, and frees: mostly of chains handed out earlier, some of arbitrary heads
   function automatic dca_pkg::req_type next_random();
      dca_pkg::req_type r;
      int               pick;
      int               roll;
      r.is_write   = 1'($urandom_range(1));
      r.head_index = dca_pkg::HEAD_W'($urandom_range(15));
      roll = $urandom_range(99);
      if (roll < 45) begin
         r.mode = dca_pkg::MODE_ALLOC;
      end else begin
         r.mode = dca_pkg::MODE_FREE;
         if (roll < 87 && live_heads.size() != 0) begin
            pick = $urandom_range(live_heads.size() - 1);
            r.head_index = live_heads[pick];
            live_heads.delete(pick);
         end
      end
      return r;
   endfunction

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_request(directed[i]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 300 && n < 420);
         send_request(next_random());
      end
      calm = 1'b0;
      req_if.valid <= 1'b0;
      while (table_model.awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (table_model.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/dca_pkg.sv
hw/rtl/dca_stream_if.sv
hw/rtl/dca_datapath.sv
hw/rtl/dca_ctrl.sv
hw/rtl/descriptor_chain_allocator.sv
sim/descriptor_chain_allocator_test.sv
